// ===== hdl/rrep_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray rectangle exit point: shared package
// Constants, codes and the arctangent table used by the exit point pipeline.
// ----------------------------------------------------------------------------
package rrep_pkg;

    localparam int COORD_WIDTH_DEF     = 32;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // CORDIC datapath: cosine and sine in signed Q4.30, angle in Q.24 degrees.
    localparam int CORDIC_STEPS = 26;
    localparam int ZFRAC        = 24;
    localparam int CS_W         = 34;
    localparam int ZW           = 33;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);

    localparam logic signed [ZW-1:0] ATAN_TBL [0:CORDIC_STEPS-1] = '{
        ZW'(754974720), ZW'(445687602), ZW'(235489088), ZW'(119537938),
        ZW'(60000934),  ZW'(30029717),  ZW'(15018523),  ZW'(7509720),
        ZW'(3754917),   ZW'(1877466),   ZW'(938734),    ZW'(469367),
        ZW'(234684),    ZW'(117342),    ZW'(58671),     ZW'(29335),
        ZW'(14668),     ZW'(7334),      ZW'(3667),      ZW'(1833),
        ZW'(917),       ZW'(458),       ZW'(229),       ZW'(115),
        ZW'(57),        ZW'(29)
    };

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN = 3'd0,
        CFG_X_MAX = 3'd1,
        CFG_Y_MIN = 3'd2,
        CFG_Y_MAX = 3'd3
    } cfg_idx_t;

    // Edge codes of the result.
    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_LEFT   = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_RIGHT  = 2'd3
    } edge_t;

endpackage

// ===== hdl/rrep_if.sv =====
// ----------------------------------------------------------------------------
// Ray rectangle exit point: channel interfaces
// Valid/ready channels for ray requests and exit point results.
// ----------------------------------------------------------------------------
interface rrep_req_if #(
    parameter int COORD_WIDTH     = 32,
    parameter int ANGLE_FRAC_BITS = 16
);
    logic                                valid;
    logic                                ready;
    logic signed [COORD_WIDTH-1:0]       start_x;
    logic signed [COORD_WIDTH-1:0]       start_y;
    logic        [8+ANGLE_FRAC_BITS:0]   direction_deg;

    modport source (output valid, output start_x, output start_y,
                    output direction_deg, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input direction_deg, output ready);
endinterface

interface rrep_res_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic        [1:0]             exit_edge;
    logic                          degenerate;

    modport source (output valid, output end_x, output end_y,
                    output exit_edge, output degenerate, input ready);
    modport sink   (input valid, input end_x, input end_y,
                    input exit_edge, input degenerate, output ready);
endinterface

// ===== hdl/ray_rectangle_exit_point.sv =====
// ----------------------------------------------------------------------------
// Ray rectangle exit point
// Finds where a ray from a start point leaves a configured axis rectangle.
// ----------------------------------------------------------------------------
// Usage: software writes the four rectangle borders (signed Q16.16) through
// the cfg_we/cfg_index/cfg_data port while the block is idle. Each request
// on the req channel carries a start point and a direction in degrees; the
// res channel returns one result per request, in order: the exit point,
// the edge that was hit and a degenerate flag.
// The pipeline stages, in order: one stage
// reduces the angle to a quadrant, 26 CORDIC stages make cosine and sine,
// one stage forms the corner cross products, one picks the edge, one
// multiplies, one builds the rounding numerator, COORD_WIDTH + 1 restoring
// divider stages produce one quotient bit each, and one stage adds,
// saturates and drives the output register.
// Throughput is one request per cycle unless a stalled result holds the pipe;
// the pipeline depth is set by the CORDIC chain and the bit-per-stage divider.
// Reset clears every valid bit and sets all borders to zero; payload
// registers keep whatever they hold.
// When the receiver holds res.ready low with a result waiting, the whole
// pipeline freezes in place and req.ready drops; nothing is lost or
// repeated, and a request is taken again as soon as the result leaves.
// ----------------------------------------------------------------------------
module ray_rectangle_exit_point
    import rrep_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    rrep_req_if.sink               req,
    rrep_res_if.source             res
);

    localparam int AW  = 9 + ANGLE_FRAC_BITS;      // angle width
    localparam int DW  = COORD_WIDTH + 1;          // border distance width
    localparam int PW  = DW + CS_W;                // corner product width
    localparam int XW  = PW + 1;                   // cross product width
    localparam int NW  = DW + CS_W + 1;            // rounding numerator width
    localparam int DNW = CS_W + 1;                 // divisor width
    localparam int QW  = COORD_WIDTH + 1;          // quotient bits kept
    localparam int SW  = COORD_WIDTH + 3;          // final sum width

    localparam logic [AW-1:0] FULL_TURN = AW'(64'd360 << ANGLE_FRAC_BITS);
    localparam logic [ZW-1:0] Z_Q1 = ZW'(64'd90 << ZFRAC);
    localparam logic [ZW-1:0] Z_Q2 = ZW'(64'd180 << ZFRAC);
    localparam logic [ZW-1:0] Z_Q3 = ZW'(64'd270 << ZFRAC);

    localparam logic signed [SW-1:0] SAT_MAX = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= '0;
            x_max_reg <= '0;
            y_min_reg <= '0;
            y_max_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_X_MIN: x_min_reg <= cfg_data;
                CFG_X_MAX: x_max_reg <= cfg_data;
                CFG_Y_MIN: y_min_reg <= cfg_data;
                CFG_Y_MAX: y_max_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global pipeline enable: the pipe moves unless a result is stuck.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic en;

    assign en        = !out_valid_reg || res.ready;
    assign req.ready = en;

    // ------------------------------------------------------------------
    // Stage 0: angle reduction, inside test and border distances
    // ------------------------------------------------------------------
    logic [AW-1:0]          ang_red;
    logic [ZW-1:0]          z_full;
    logic [1:0]             quad_next;
    logic [ZW-1:0]          z0_next;
    logic                   inside_next;
    logic signed [DW-1:0]   xr_next, xl_next, yt_next, yb_next;

    always_comb
    begin
        ang_red = (req.direction_deg >= FULL_TURN) ? req.direction_deg - FULL_TURN
                                                   : req.direction_deg;
        z_full  = ZW'(ang_red) << (ZFRAC - ANGLE_FRAC_BITS);
        if (z_full >= Z_Q3)
        begin
            quad_next = 2'd3;
            z0_next   = z_full - Z_Q3;
        end
        else if (z_full >= Z_Q2)
        begin
            quad_next = 2'd2;
            z0_next   = z_full - Z_Q2;
        end
        else if (z_full >= Z_Q1)
        begin
            quad_next = 2'd1;
            z0_next   = z_full - Z_Q1;
        end
        else
        begin
            quad_next = 2'd0;
            z0_next   = z_full;
        end
        inside_next = (x_min_reg < req.start_x) && (req.start_x < x_max_reg) &&
                      (y_min_reg < req.start_y) && (req.start_y < y_max_reg);
        xr_next = DW'(x_max_reg) - DW'(req.start_x);
        xl_next = DW'(x_min_reg) - DW'(req.start_x);
        yt_next = DW'(y_max_reg) - DW'(req.start_y);
        yb_next = DW'(y_min_reg) - DW'(req.start_y);
    end

    // ------------------------------------------------------------------
    // CORDIC rotation chain, one micro-rotation per stage.
    // Index 0 holds the stage 0 output.
    // ------------------------------------------------------------------
    logic                          cv_reg   [0:CORDIC_STEPS];
    logic signed [CS_W-1:0]        x_reg    [0:CORDIC_STEPS];
    logic signed [CS_W-1:0]        y_reg    [0:CORDIC_STEPS];
    logic signed [ZW-1:0]          z_reg    [0:CORDIC_STEPS];
    logic [1:0]                    quad_reg [0:CORDIC_STEPS];
    logic                          in_reg   [0:CORDIC_STEPS];
    logic signed [COORD_WIDTH-1:0] sx_reg   [0:CORDIC_STEPS];
    logic signed [COORD_WIDTH-1:0] sy_reg   [0:CORDIC_STEPS];
    logic signed [DW-1:0]          xr_reg   [0:CORDIC_STEPS];
    logic signed [DW-1:0]          xl_reg   [0:CORDIC_STEPS];
    logic signed [DW-1:0]          yt_reg   [0:CORDIC_STEPS];
    logic signed [DW-1:0]          yb_reg   [0:CORDIC_STEPS];

    logic signed [CS_W-1:0] x_next [1:CORDIC_STEPS];
    logic signed [CS_W-1:0] y_next [1:CORDIC_STEPS];
    logic signed [ZW-1:0]   z_next [1:CORDIC_STEPS];

    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!z_reg[i][ZW-1])
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] - ATAN_TBL[i];
            end
            else
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i] + ATAN_TBL[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_STEPS; i++)
            begin
                cv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            cv_reg[0] <= req.valid;
            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                cv_reg[i] <= cv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z0_next;
            quad_reg[0] <= quad_next;
            in_reg[0]   <= inside_next;
            sx_reg[0]   <= req.start_x;
            sy_reg[0]   <= req.start_y;
            xr_reg[0]   <= xr_next;
            xl_reg[0]   <= xl_next;
            yt_reg[0]   <= yt_next;
            yb_reg[0]   <= yb_next;
            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
                quad_reg[i] <= quad_reg[i-1];
                in_reg[i]   <= in_reg[i-1];
                sx_reg[i]   <= sx_reg[i-1];
                sy_reg[i]   <= sy_reg[i-1];
                xr_reg[i]   <= xr_reg[i-1];
                xl_reg[i]   <= xl_reg[i-1];
                yt_reg[i]   <= yt_reg[i-1];
                yb_reg[i]   <= yb_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Product stage: quadrant unfold and the four corner products.
    // ------------------------------------------------------------------
    logic signed [CS_W-1:0] c_next, s_next;
    logic signed [PW-1:0]   p_xr_s_next, p_xl_s_next, p_yt_c_next, p_yb_c_next;

    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            2'd0:
            begin
                c_next = x_reg[CORDIC_STEPS];
                s_next = y_reg[CORDIC_STEPS];
            end
            2'd1:
            begin
                c_next = -y_reg[CORDIC_STEPS];
                s_next = x_reg[CORDIC_STEPS];
            end
            2'd2:
            begin
                c_next = -x_reg[CORDIC_STEPS];
                s_next = -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                c_next = y_reg[CORDIC_STEPS];
                s_next = -x_reg[CORDIC_STEPS];
            end
        endcase
        p_xr_s_next = xr_reg[CORDIC_STEPS] * s_next;
        p_xl_s_next = xl_reg[CORDIC_STEPS] * s_next;
        p_yt_c_next = yt_reg[CORDIC_STEPS] * c_next;
        p_yb_c_next = yb_reg[CORDIC_STEPS] * c_next;
    end

    logic                          p1_valid_reg;
    logic signed [CS_W-1:0]        p1_c_reg, p1_s_reg;
    logic signed [PW-1:0]          p1_xr_s_reg, p1_xl_s_reg, p1_yt_c_reg, p1_yb_c_reg;
    logic                          p1_in_reg;
    logic signed [COORD_WIDTH-1:0] p1_sx_reg, p1_sy_reg;
    logic signed [DW-1:0]          p1_xr_reg, p1_xl_reg, p1_yt_reg, p1_yb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_c_reg    <= c_next;
            p1_s_reg    <= s_next;
            p1_xr_s_reg <= p_xr_s_next;
            p1_xl_s_reg <= p_xl_s_next;
            p1_yt_c_reg <= p_yt_c_next;
            p1_yb_c_reg <= p_yb_c_next;
            p1_in_reg   <= in_reg[CORDIC_STEPS];
            p1_sx_reg   <= sx_reg[CORDIC_STEPS];
            p1_sy_reg   <= sy_reg[CORDIC_STEPS];
            p1_xr_reg   <= xr_reg[CORDIC_STEPS];
            p1_xl_reg   <= xl_reg[CORDIC_STEPS];
            p1_yt_reg   <= yt_reg[CORDIC_STEPS];
            p1_yb_reg   <= yb_reg[CORDIC_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // Edge stage: cross product signs pick the sector, then the operands
    // of the offset t * u / v are chosen and turned into magnitudes.
    // A direction exactly on a corner goes to the earlier edge.
    // ------------------------------------------------------------------
    logic signed [XW-1:0]          cr_tr, cr_tl, cr_bl, cr_br;
    logic                          horiz_next, degen_next, neg_next;
    edge_t                         edge_next;
    logic signed [DW-1:0]          t_sel;
    logic signed [CS_W-1:0]        u_sel, v_sel;
    logic [DW-1:0]                 tm_next;
    logic [CS_W-1:0]               um_next, vm_next;
    logic signed [COORD_WIDTH-1:0] base_next, fixed_next;
    logic signed [DW-1:0]          anchor;

    always_comb
    begin
        cr_tr = p1_xr_s_reg - p1_yt_c_reg;
        cr_tl = p1_xl_s_reg - p1_yt_c_reg;
        cr_bl = p1_xl_s_reg - p1_yb_c_reg;
        cr_br = p1_xr_s_reg - p1_yb_c_reg;
        if (!cr_tr[XW-1] && (cr_tl[XW-1] || cr_tl == '0))
        begin
            edge_next = EDGE_TOP;
        end
        else if (!cr_tl[XW-1] && (cr_bl[XW-1] || cr_bl == '0))
        begin
            edge_next = EDGE_LEFT;
        end
        else if (!cr_bl[XW-1] && (cr_br[XW-1] || cr_br == '0))
        begin
            edge_next = EDGE_BOTTOM;
        end
        else
        begin
            edge_next = EDGE_RIGHT;
        end

        case (edge_next)
            EDGE_TOP:    t_sel = p1_yt_reg;
            EDGE_LEFT:   t_sel = p1_xl_reg;
            EDGE_BOTTOM: t_sel = p1_yb_reg;
            default:     t_sel = p1_xr_reg;
        endcase
        horiz_next = (edge_next == EDGE_TOP) || (edge_next == EDGE_BOTTOM);
        u_sel      = horiz_next ? p1_c_reg : p1_s_reg;
        v_sel      = horiz_next ? p1_s_reg : p1_c_reg;
        neg_next   = t_sel[DW-1] ^ u_sel[CS_W-1] ^ v_sel[CS_W-1];
        tm_next    = t_sel[DW-1] ? DW'(-t_sel) : DW'(t_sel);
        um_next    = u_sel[CS_W-1] ? CS_W'(-u_sel) : CS_W'(u_sel);
        vm_next    = v_sel[CS_W-1] ? CS_W'(-v_sel) : CS_W'(v_sel);
        degen_next = !p1_in_reg || (v_sel == '0);

        // The border coordinate is the start plus its distance to it.
        anchor     = horiz_next ? DW'(p1_sy_reg) : DW'(p1_sx_reg);
        fixed_next = COORD_WIDTH'(anchor + t_sel);
        base_next  = horiz_next ? p1_sx_reg : p1_sy_reg;

        // A degenerate ray reports its own start point on the top code.
        if (degen_next)
        begin
            edge_next  = EDGE_TOP;
            horiz_next = 1'b1;
            base_next  = p1_sx_reg;
            fixed_next = p1_sy_reg;
        end
    end

    logic                          p2_valid_reg;
    logic [DW-1:0]                 p2_tm_reg;
    logic [CS_W-1:0]               p2_um_reg, p2_vm_reg;
    logic                          p2_neg_reg, p2_horiz_reg, p2_degen_reg;
    edge_t                         p2_edge_reg;
    logic signed [COORD_WIDTH-1:0] p2_base_reg, p2_fixed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_tm_reg    <= tm_next;
            p2_um_reg    <= um_next;
            p2_vm_reg    <= vm_next;
            p2_neg_reg   <= neg_next;
            p2_horiz_reg <= horiz_next;
            p2_degen_reg <= degen_next;
            p2_edge_reg  <= edge_next;
            p2_base_reg  <= base_next;
            p2_fixed_reg <= fixed_next;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: |t| * |u|.
    // ------------------------------------------------------------------
    logic                          p3_valid_reg;
    logic [DW+CS_W-1:0]            p3_prod_reg;
    logic [CS_W-1:0]               p3_vm_reg;
    logic                          p3_neg_reg, p3_horiz_reg, p3_degen_reg;
    edge_t                         p3_edge_reg;
    logic signed [COORD_WIDTH-1:0] p3_base_reg, p3_fixed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_prod_reg  <= p2_tm_reg * p2_um_reg;
            p3_vm_reg    <= p2_vm_reg;
            p3_neg_reg   <= p2_neg_reg;
            p3_horiz_reg <= p2_horiz_reg;
            p3_degen_reg <= p2_degen_reg;
            p3_edge_reg  <= p2_edge_reg;
            p3_base_reg  <= p2_base_reg;
            p3_fixed_reg <= p2_fixed_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: round to nearest by dividing 2|t u| + |v| by 2|v|.
    // Quotients of 2^QW and above saturate anyway, so they only set the
    // overflow flag; the rest come out of QW restoring stages.
    // ------------------------------------------------------------------
    logic [NW-1:0]  num_next;
    logic [DNW-1:0] den_next;
    logic           ovf_next;

    always_comb
    begin
        num_next = {p3_prod_reg, 1'b0} + NW'(p3_vm_reg);
        den_next = {p3_vm_reg, 1'b0};
        ovf_next = num_next[NW-1:QW] >= den_next;
    end

    logic                          dv_reg    [0:QW];
    logic [DNW-1:0]                rem_reg   [0:QW];
    logic [QW-1:0]                 low_reg   [0:QW];
    logic [QW-1:0]                 q_reg     [0:QW];
    logic [DNW-1:0]                den_reg   [0:QW];
    logic                          ovf_reg   [0:QW];
    logic                          neg_reg   [0:QW];
    logic                          horiz_reg [0:QW];
    logic                          degen_reg [0:QW];
    edge_t                         edge_reg  [0:QW];
    logic signed [COORD_WIDTH-1:0] base_reg  [0:QW];
    logic signed [COORD_WIDTH-1:0] fixed_reg [0:QW];

    logic [DNW:0]   trial   [0:QW-1];
    logic [DNW-1:0] rem_next [1:QW];
    logic [QW-1:0]  low_next [1:QW];
    logic [QW-1:0]  q_next   [1:QW];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trial[k]      = {rem_reg[k], low_reg[k][QW-1]};
            low_next[k+1] = low_reg[k] << 1;
            if (trial[k] >= {1'b0, den_reg[k]})
            begin
                rem_next[k+1] = DNW'(trial[k] - {1'b0, den_reg[k]});
                q_next[k+1]   = {q_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1] = DNW'(trial[k]);
                q_next[k+1]   = {q_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            dv_reg[0] <= p3_valid_reg;
            for (int k = 1; k <= QW; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= num_next[NW-1:QW];
            low_reg[0]   <= num_next[QW-1:0];
            q_reg[0]     <= '0;
            den_reg[0]   <= den_next;
            ovf_reg[0]   <= ovf_next;
            neg_reg[0]   <= p3_neg_reg;
            horiz_reg[0] <= p3_horiz_reg;
            degen_reg[0] <= p3_degen_reg;
            edge_reg[0]  <= p3_edge_reg;
            base_reg[0]  <= p3_base_reg;
            fixed_reg[0] <= p3_fixed_reg;
            for (int k = 1; k <= QW; k++)
            begin
                rem_reg[k]   <= rem_next[k];
                low_reg[k]   <= low_next[k];
                q_reg[k]     <= q_next[k];
                den_reg[k]   <= den_reg[k-1];
                ovf_reg[k]   <= ovf_reg[k-1];
                neg_reg[k]   <= neg_reg[k-1];
                horiz_reg[k] <= horiz_reg[k-1];
                degen_reg[k] <= degen_reg[k-1];
                edge_reg[k]  <= edge_reg[k-1];
                base_reg[k]  <= base_reg[k-1];
                fixed_reg[k] <= fixed_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: signed offset, add, saturate, place on the edge.
    // ------------------------------------------------------------------
    logic signed [SW-1:0]          off, sum;
    logic signed [COORD_WIDTH-1:0] moved;
    logic signed [COORD_WIDTH-1:0] end_x_next, end_y_next;

    always_comb
    begin
        off = neg_reg[QW] ? -SW'(q_reg[QW]) : SW'(q_reg[QW]);
        sum = SW'(base_reg[QW]) + off;
        if (degen_reg[QW])
        begin
            moved = base_reg[QW];
        end
        else if (ovf_reg[QW])
        begin
            moved = neg_reg[QW] ? COORD_WIDTH'(SAT_MIN) : COORD_WIDTH'(SAT_MAX);
        end
        else if (sum > SAT_MAX)
        begin
            moved = COORD_WIDTH'(SAT_MAX);
        end
        else if (sum < SAT_MIN)
        begin
            moved = COORD_WIDTH'(SAT_MIN);
        end
        else
        begin
            moved = COORD_WIDTH'(sum);
        end
        end_x_next = horiz_reg[QW] ? moved : fixed_reg[QW];
        end_y_next = horiz_reg[QW] ? fixed_reg[QW] : moved;
    end

    logic signed [COORD_WIDTH-1:0] end_x_reg, end_y_reg;
    edge_t                         exit_edge_reg;
    logic                          degenerate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            end_x_reg      <= end_x_next;
            end_y_reg      <= end_y_next;
            exit_edge_reg  <= edge_reg[QW];
            degenerate_reg <= degen_reg[QW];
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.end_x      = end_x_reg;
    assign res.end_y      = end_y_reg;
    assign res.exit_edge  = exit_edge_reg;
    assign res.degenerate = degenerate_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_degen_edge: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.degenerate |-> res.exit_edge == EDGE_TOP)
        else $error("degenerate result carries a non-top edge code");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> res.valid && !res.ready)
        else $error("request side stalled without a blocked result");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[QW] && !ovf_reg[QW] |-> rem_reg[QW] < den_reg[QW])
        else $error("divider remainder not below divisor");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(dv_reg[QW]))
        else $error("result appeared without an item in the last divider stage");

endmodule

// ===== tb/sv/tb_ray_rectangle_exit_point.sv =====
// ----------------------------------------------------------------------------
// Ray rectangle exit point: self-checking testbench
// Sends rays through the block under several rectangle settings, predicts
// every exit point with a bit-exact CORDIC and edge-selection model of its
// own, and compares each result in order, field by field.
// ----------------------------------------------------------------------------
class exit_point_scoreboard;

    typedef struct packed {
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        rrep_pkg::edge_t    exit_edge;
        logic               degenerate;
    } exit_t;

    longint x_min, x_max, y_min, y_max;
    exit_t  expected_exits[$];
    int     errors;

    function new();
        x_min = 0;
        x_max = 0;
        y_min = 0;
        y_max = 0;
        errors = 0;
    endfunction

    function void set_border(rrep_pkg::cfg_idx_t idx, logic signed [31:0] val);
        case (idx)
            rrep_pkg::CFG_X_MIN: x_min = val;
            rrep_pkg::CFG_X_MAX: x_max = val;
            rrep_pkg::CFG_Y_MIN: y_min = val;
            rrep_pkg::CFG_Y_MAX: y_max = val;
            default: ;
        endcase
    endfunction

    function void cos_sin(input logic [24:0] dir, output longint c, output longint s);
        longint ang, z, x, y, dx, dy;
        int quad;
        ang = dir;
        if (ang >= (longint'(360) << 16))
            ang -= longint'(360) << 16;
        z = ang << 8;
        quad = 0;
        while (z >= (longint'(90) << 24) && quad < 3)
        begin
            z -= longint'(90) << 24;
            quad++;
        end
        x = longint'(rrep_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < rrep_pkg::CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(rrep_pkg::ATAN_TBL[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(rrep_pkg::ATAN_TBL[i]);
            end
        end
        case (quad)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // Sign of a*b - c*d, exact in 128 bits.
    function int cross_sign(longint a, longint b, longint c, longint d);
        logic signed [127:0] wa, wb, wc, wd, diff;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        diff = wa * wb - wc * wd;
        if (diff < 0)
            return -1;
        return (diff == 0) ? 0 : 1;
    endfunction

    // The direction lies counterclockwise from corner a and clockwise from b.
    function bit between(longint ax, longint ay, longint bx, longint by,
                         longint c, longint s);
        return cross_sign(ax, s, ay, c) >= 0 && cross_sign(c, by, s, bx) >= 0;
    endfunction

    // round(t*u/v) with ties away from zero, magnitude capped at 2^62.
    function longint scaled_offset(longint t, longint u, longint v);
        logic [127:0] mt, mu, mv, q;
        bit neg;
        mt = (t < 0) ? -t : t;
        mu = (u < 0) ? -u : u;
        mv = (v < 0) ? -v : v;
        neg = ((t < 0) != (u < 0)) != (v < 0);
        q = (2 * mt * mu + mv) / (2 * mv);
        if (q > (128'd1 << 62))
            q = 128'd1 << 62;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function logic signed [31:0] saturate(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function exit_t exit_of(longint sx, longint sy, logic [24:0] dir);
        exit_t r;
        longint xr, xl, yt, yb, c, s;
        rrep_pkg::edge_t e;
        r.end_x = sx[31:0];
        r.end_y = sy[31:0];
        r.exit_edge = rrep_pkg::EDGE_TOP;
        r.degenerate = 1'b1;
        if (x_min < sx && sx < x_max && y_min < sy && sy < y_max)
        begin
            xr = x_max - sx;
            xl = x_min - sx;
            yt = y_max - sy;
            yb = y_min - sy;
            cos_sin(dir, c, s);
            if (between(xr, yt, xl, yt, c, s))
                e = rrep_pkg::EDGE_TOP;
            else if (between(xl, yt, xl, yb, c, s))
                e = rrep_pkg::EDGE_LEFT;
            else if (between(xl, yb, xr, yb, c, s))
                e = rrep_pkg::EDGE_BOTTOM;
            else
                e = rrep_pkg::EDGE_RIGHT;
            if ((e == rrep_pkg::EDGE_TOP || e == rrep_pkg::EDGE_BOTTOM) && s != 0)
            begin
                r.end_y = (e == rrep_pkg::EDGE_TOP) ? y_max[31:0] : y_min[31:0];
                r.end_x = saturate(sx + scaled_offset(
                              (e == rrep_pkg::EDGE_TOP) ? yt : yb, c, s));
                r.exit_edge = e;
                r.degenerate = 1'b0;
            end
            else if ((e == rrep_pkg::EDGE_LEFT || e == rrep_pkg::EDGE_RIGHT) && c != 0)
            begin
                r.end_x = (e == rrep_pkg::EDGE_LEFT) ? x_min[31:0] : x_max[31:0];
                r.end_y = saturate(sy + scaled_offset(
                              (e == rrep_pkg::EDGE_LEFT) ? xl : xr, s, c));
                r.exit_edge = e;
                r.degenerate = 1'b0;
            end
        end
        return r;
    endfunction

    function void note_ray(logic signed [31:0] sx, logic signed [31:0] sy,
                           logic [24:0] dir);
        expected_exits.push_back(exit_of(sx, sy, dir));
    endfunction

    function void check_exit(exit_t got);
        exit_t want;
        if (expected_exits.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = expected_exits.pop_front();
        if (got.end_x !== want.end_x)
        begin
            $display("%0t: end_x expected %0d actual %0d", $time, want.end_x, got.end_x);
            errors++;
        end
        if (got.end_y !== want.end_y)
        begin
            $display("%0t: end_y expected %0d actual %0d", $time, want.end_y, got.end_y);
            errors++;
        end
        if (got.exit_edge !== want.exit_edge)
        begin
            $display("%0t: exit_edge expected %0d actual %0d", $time,
                     want.exit_edge, got.exit_edge);
            errors++;
        end
        if (got.degenerate !== want.degenerate)
        begin
            $display("%0t: degenerate expected %0d actual %0d", $time,
                     want.degenerate, got.degenerate);
            errors++;
        end
    endfunction

endclass

module tb_ray_rectangle_exit_point;
    import rrep_pkg::*;

    // Pipeline depth at the default width plus some margin.
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam longint ONE = 64'sd65536;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    rrep_req_if #(.COORD_WIDTH(32), .ANGLE_FRAC_BITS(16)) req_ch ();
    rrep_res_if #(.COORD_WIDTH(32)) res_ch ();

    ray_rectangle_exit_point uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .res       (res_ch)
    );

    exit_point_scoreboard exits = new();

    int cycles = 0;
    int hold_left = 0;      // long receiver hold-off, set by the stimulus
    bit steady = 0;         // when set, neither side inserts gaps

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog: the run must finish well within the cycle budget.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Every accepted request is predicted and every accepted result is
    // checked at the same rising edge the handshake completes on.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            exits.note_ray(req_ch.start_x, req_ch.start_y, req_ch.direction_deg);
        if (rst_n && res_ch.valid && res_ch.ready)
            exits.check_exit({res_ch.end_x, res_ch.end_y,
                              edge_t'(res_ch.exit_edge), res_ch.degenerate});
    end

    // Receiver: mostly ready, with short stalls, a few long ones, and a
    // long hold-off on request from the stimulus so the pipeline fills up.
    initial
    begin
        int stall;
        int pick;
        stall = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pick = $urandom_range(0, 99);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready = 1'b0;
            end
            else if (steady)
                res_ch.ready = 1'b1;
            else if (stall > 0)
            begin
                stall--;
                res_ch.ready = 1'b0;
            end
            else if (pick < 75)
                res_ch.ready = 1'b1;
            else
            begin
                stall = (pick < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                res_ch.ready = 1'b0;
            end
        end
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint rand64();
        return longint'({$urandom, $urandom});
    endfunction

    // Random value strictly between lo and hi when there is room.
    function automatic longint rand_between(longint lo, longint hi);
        longint span;
        span = hi - lo - 1;
        if (span <= 0)
            return lo;
        return lo + 1 + longint'(unsigned'(rand64()) % unsigned'(span));
    endfunction

    // Send one ray request and hold it until the block takes it.
    task automatic send_ray(longint sx, longint sy, logic [24:0] dir);
        int gap;
        @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.start_x = sx[31:0];
        req_ch.start_y = sy[31:0];
        req_ch.direction_deg = dir;
        do
            @(posedge clk);
        while (!req_ch.ready);
        gap = gap_length();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Let every outstanding request come back before touching the borders.
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (exits.expected_exits.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_border(cfg_idx_t idx, longint val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[31:0];
        exits.set_border(idx, val[31:0]);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_rectangle(longint xl, longint xh, longint yl, longint yh);
        wait_drained();
        write_border(CFG_Y_MAX, yh);
        write_border(CFG_X_MIN, xl);
        write_border(CFG_Y_MIN, yl);
        write_border(CFG_X_MAX, xh);
    endtask

    // Random rays: mostly from inside the rectangle, some from anywhere.
    task automatic random_rays(int count);
        longint sx, sy;
        logic [24:0] dir;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                sx = rand_between(exits.x_min, exits.x_max);
                sy = rand_between(exits.y_min, exits.y_max);
            end
            else
            begin
                sx = longint'(signed'($urandom));
                sy = longint'(signed'($urandom));
            end
            // Mostly proper angles below 360, now and then the wrapping range.
            if ($urandom_range(0, 9) < 9)
                dir = $urandom_range(0, (360 << 16) - 1);
            else
                dir = $urandom;
            send_ray(sx, sy, dir);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.start_x = '0;
        req_ch.start_y = '0;
        req_ch.direction_deg = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Reset borders give an empty rectangle: every ray is degenerate.
        send_ray(0, 0, 0);
        send_ray(5, -5, 25'd90 << 16);

        // Square of side 200 around the origin; the corners sit exactly on
        // the diagonals, which exercises the tie rule between edges.
        set_rectangle(-100 * ONE, 100 * ONE, -100 * ONE, 100 * ONE);
        for (int k = 0; k < 8; k++)
            send_ray(0, 0, 25'(k * 45) << 16);
        send_ray(0, 0, 25'((360 << 16) - 1));
        send_ray(0, 0, 25'(360 << 16));              // wraps back to zero
        send_ray(0, 0, 25'h1FFFFFF);                 // top of the field
        send_ray(100 * ONE, 0, 0);                   // start on the border
        send_ray(0, -100 * ONE, 25'd90 << 16);
        send_ray(300 * ONE, 0, 25'd180 << 16);       // start outside
        send_ray(-100 * ONE + 1, 100 * ONE - 1, 25'd135 << 16);
        send_ray(99 * ONE, -99 * ONE, 25'd10 << 16);
        send_ray(64'sh7FFFFFFF, 64'sh7FFFFFFF, 25'd1);
        send_ray(-64'sh80000000, -64'sh80000000, 25'd1);
        random_rays(200);

        // Borders at the extremes of the coordinate range: exit points
        // far out, and saturation on near-flat rays.
        set_rectangle(-64'sh80000000, 64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF);
        send_ray(0, 0, 25'd1);
        send_ray(0, 0, (25'd90 << 16) - 25'd1);
        send_ray(64'sh7FFFFFFE, -64'sh7FFFFFFF, 25'd45 << 16);
        random_rays(250);

        // Smallest box with a single interior point.
        set_rectangle(0, 2, 0, 2);
        random_rays(100);

        // Wide flat box; the receiver holds off for a long stretch so the
        // block fills up and stalls its input, with no gaps on either side.
        set_rectangle(-30000 * ONE, 30000 * ONE, -1, 3);
        steady = 1;
        hold_left = 300;
        random_rays(250);
        steady = 0;

        // Inverted borders make the rectangle empty.
        set_rectangle(10 * ONE, -10 * ONE, 5 * ONE, -5 * ONE);
        random_rays(40);

        // Random rectangles, ordered borders, full-range corners.
        for (int p = 0; p < 4; p++)
        begin
            longint a, b, c, d;
            a = longint'(signed'($urandom));
            b = longint'(signed'($urandom));
            c = longint'(signed'($urandom));
            d = longint'(signed'($urandom));
            set_rectangle(a < b ? a : b, a < b ? b : a, c < d ? c : d, c < d ? d : c);
            random_rays(230);
        end

        wait_drained();
        if (exits.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rrep_pkg.sv
hdl/rrep_if.sv
hdl/ray_rectangle_exit_point.sv
tb/sv/tb_ray_rectangle_exit_point.sv
